// ----- sv/bhpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_pkg
// shared types, codes and defaults of the binary heap priority queue
// ----------------------------------------------------------------------------
package bhpq_pkg;

    localparam int DEF_CAPACITY      = 64;
    localparam int DEF_PRIORITY_BITS = 8;
    localparam int DEF_TAG_BITS      = 16;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_RM_RD,
        ST_RM_CAP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FINISH
    } t_state;

    typedef enum logic {
        SIFT_UP,
        SIFT_DOWN
    } t_sift_mode;

    // decision of one sift level
    typedef struct packed {
        logic move;        // hole moves, the compared entry shifts into it
        logic pick_right;  // sift-down: the right child is the one moved
    } t_sift_dec;

endpackage

// ----- sv/bhpq_sift_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_sift_unit
// shared key compare of one sift level, used for both sift-up and sift-down
// ----------------------------------------------------------------------------
module bhpq_sift_unit #(
    parameter int KEY_BITS = bhpq_pkg::DEF_PRIORITY_BITS
) (
    input  bhpq_pkg::t_sift_mode i_mode,
    input  logic [KEY_BITS-1:0]  i_cur_key,
    input  logic [KEY_BITS-1:0]  i_key_a,     // parent (up) or left child (down)
    input  logic [KEY_BITS-1:0]  i_key_b,     // right child (down)
    input  logic                 i_left_ok,
    input  logic                 i_right_ok,
    output bhpq_pkg::t_sift_dec  o_dec
);

    logic                left_lt;
    logic                right_lt;
    logic [KEY_BITS-1:0] best_key;

    always_comb begin
        left_lt  = i_left_ok && (i_key_a < i_cur_key);
        best_key = left_lt ? i_key_a : i_cur_key;
        right_lt = i_right_ok && (i_key_b < i_key_a) && (i_key_b < best_key);
        case (i_mode)
            bhpq_pkg::SIFT_UP: begin
                o_dec.move       = i_cur_key < i_key_a;
                o_dec.pick_right = 1'b0;
            end
            bhpq_pkg::SIFT_DOWN: begin
                o_dec.move       = left_lt || right_lt;
                o_dec.pick_right = right_lt;
            end
            default: begin
                o_dec.move       = 1'b0;
                o_dec.pick_right = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/binary_heap_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// min-first priority queue kept as a binary heap in an on-chip memory
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid/o_ready) carries one command beat: insert of
//   i_priority_req/i_tag, or remove of the smallest priority entry
//   output channel (o_valid/i_ready) returns exactly one result beat per
//   command: status, removed priority and tag (zero unless a remove
//   succeeded) and the entry count after the command
//   one command is worked at a time; o_ready is high only while idle
//   an insert opens a hole at the new last slot and lets it climb toward
//   the root; a remove reads the root and the last entry, hands out the
//   root and lets the last entry sift down from the root; a remove of the
//   only entry ends there, and a refused insert (full) or remove (empty)
//   goes straight to the result
//   every level takes a memory read state and then a compare/write state,
//   and the next command is taken once the sequencer is back in idle
//   a result waits in the output register while i_ready is low; the next
//   command is accepted meanwhile and stalls only at its own result
//   reset empties the heap at once (count to zero), no clearing pass
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
    parameter int CAPACITY      = bhpq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_BITS = bhpq_pkg::DEF_PRIORITY_BITS,
    parameter int TAG_BITS      = bhpq_pkg::DEF_TAG_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_command,
    input  logic [PRIORITY_BITS-1:0]           i_priority_req,
    input  logic [TAG_BITS-1:0]                i_tag,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic [PRIORITY_BITS-1:0]           o_out_priority,
    output logic [TAG_BITS-1:0]                o_out_tag,
    output logic [$clog2(CAPACITY+1)-1:0]      o_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);   // slot index and count width
    localparam int AW = $clog2(CAPACITY);       // memory address width
    localparam int EW = PRIORITY_BITS + TAG_BITS;

    // heap memory: slot s lives at address s-1, key above tag
    logic [EW-1:0] r_mem [CAPACITY];

    bhpq_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_pos, n_pos;         // current hole of the sift
    logic [EW-1:0]    r_cur, n_cur;         // entry being sifted
    logic [1:0]       r_res_status, n_res_status;
    logic [EW-1:0]    r_res_entry, n_res_entry;
    logic [EW-1:0]    r_rd_a, r_rd_b;       // registered memory read data

    logic             r_o_valid;
    logic [1:0]       r_o_status;
    logic [EW-1:0]    r_o_entry;
    logic [CW-1:0]    r_o_occ;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [EW-1:0]    w_wdata;
    logic [AW-1:0]    w_ra, w_rb;
    logic             w_load;

    logic [CW:0]      w_left;               // left child slot, one bit wider
    logic             w_left_ok, w_right_ok;
    logic [CW-1:0]    w_parent;
    logic [CW-1:0]    w_pos_m1, w_parent_m1, w_count_m1;
    logic [CW:0]      w_left_m1;

    bhpq_pkg::t_sift_mode w_mode;
    bhpq_pkg::t_sift_dec  w_dec;

    // slot arithmetic around the hole
    assign w_left      = {r_pos, 1'b0};
    assign w_left_ok   = w_left <= {1'b0, r_count};
    assign w_right_ok  = w_left <  {1'b0, r_count};
    assign w_parent    = r_pos >> 1;
    assign w_pos_m1    = r_pos - CW'(1);
    assign w_parent_m1 = w_parent - CW'(1);
    assign w_count_m1  = r_count - CW'(1);
    assign w_left_m1   = w_left - (CW+1)'(1);

    assign w_mode = (r_state == bhpq_pkg::ST_UP_CMP) ? bhpq_pkg::SIFT_UP
                                                      : bhpq_pkg::SIFT_DOWN;

    // the one compare unit shared by every level of both sifts
    bhpq_sift_unit #(
        .KEY_BITS (PRIORITY_BITS)
    ) u_sift (
        .i_mode     (w_mode),
        .i_cur_key  (r_cur[EW-1:TAG_BITS]),
        .i_key_a    (r_rd_a[EW-1:TAG_BITS]),
        .i_key_b    (r_rd_b[EW-1:TAG_BITS]),
        .i_left_ok  (w_left_ok),
        .i_right_ok (w_right_ok),
        .o_dec      (w_dec)
    );

    // memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[w_ra];
        r_rd_b <= r_mem[w_rb];
    end

    assign o_ready = (r_state == bhpq_pkg::ST_IDLE);

    // sequencer: next state, memory control and result capture
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_cur        = r_cur;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        w_we         = 1'b0;
        w_waddr      = w_pos_m1[AW-1:0];
        w_wdata      = r_cur;
        w_ra         = '0;
        w_rb         = '0;
        w_load       = 1'b0;
        case (r_state)
            bhpq_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_res_entry  = '0;
                    n_res_status = bhpq_pkg::STATUS_OK;
                    if (i_command == bhpq_pkg::CMD_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_res_status = bhpq_pkg::STATUS_FULL;
                            n_state      = bhpq_pkg::ST_FINISH;
                        end else begin
                            n_count = r_count + CW'(1);
                            n_pos   = r_count + CW'(1);
                            n_cur   = {i_priority_req, i_tag};
                            n_state = bhpq_pkg::ST_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = bhpq_pkg::STATUS_EMPTY;
                            n_state      = bhpq_pkg::ST_FINISH;
                        end else begin
                            n_state = bhpq_pkg::ST_RM_RD;
                        end
                    end
                end
            end
            bhpq_pkg::ST_UP_RD: begin
                if (r_pos == CW'(1)) begin
                    // reached the root, drop the entry here
                    w_we    = 1'b1;
                    n_state = bhpq_pkg::ST_FINISH;
                end else begin
                    w_ra    = w_parent_m1[AW-1:0];
                    n_state = bhpq_pkg::ST_UP_CMP;
                end
            end
            bhpq_pkg::ST_UP_CMP: begin
                w_we = 1'b1;
                if (w_dec.move) begin
                    // parent slides down into the hole
                    w_wdata = r_rd_a;
                    n_pos   = w_parent;
                    n_state = bhpq_pkg::ST_UP_RD;
                end else begin
                    n_state = bhpq_pkg::ST_FINISH;
                end
            end
            bhpq_pkg::ST_RM_RD: begin
                w_ra    = '0;
                w_rb    = w_count_m1[AW-1:0];
                n_state = bhpq_pkg::ST_RM_CAP;
            end
            bhpq_pkg::ST_RM_CAP: begin
                // root goes out, last entry sifts down from the root
                n_res_entry = r_rd_a;
                n_cur       = r_rd_b;
                n_count     = w_count_m1;
                n_pos       = CW'(1);
                n_state     = (r_count == CW'(1)) ? bhpq_pkg::ST_FINISH
                                                  : bhpq_pkg::ST_DN_RD;
            end
            bhpq_pkg::ST_DN_RD: begin
                if (!w_left_ok) begin
                    w_we    = 1'b1;
                    n_state = bhpq_pkg::ST_FINISH;
                end else begin
                    w_ra    = w_left_m1[AW-1:0];
                    w_rb    = w_left[AW-1:0];
                    n_state = bhpq_pkg::ST_DN_CMP;
                end
            end
            bhpq_pkg::ST_DN_CMP: begin
                w_we = 1'b1;
                if (w_dec.move) begin
                    // smaller child slides up into the hole
                    w_wdata = w_dec.pick_right ? r_rd_b : r_rd_a;
                    n_pos   = w_dec.pick_right ? w_left[CW-1:0] + CW'(1)
                                               : w_left[CW-1:0];
                    n_state = bhpq_pkg::ST_DN_RD;
                end else begin
                    n_state = bhpq_pkg::ST_FINISH;
                end
            end
            bhpq_pkg::ST_FINISH: begin
                if (!r_o_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = bhpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bhpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhpq_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_cur        <= n_cur;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
    end

    // output register, parts the sequencer from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status <= r_res_status;
            r_o_entry  <= r_res_entry;
            r_o_occ    <= r_count;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_out_priority = r_o_entry[EW-1:TAG_BITS];
    assign o_out_tag      = r_o_entry[TAG_BITS-1:0];
    assign o_occupancy    = r_o_occ;

    // count never exceeds the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a remove on an empty heap is refused and leaves the count alone
    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_command == bhpq_pkg::CMD_REMOVE && r_count == '0)
        |=> (r_res_status == bhpq_pkg::STATUS_EMPTY && r_count == '0
             && r_state == bhpq_pkg::ST_FINISH))
        else $error("empty remove not refused");

    // the sift hole stays inside the filled slots
    a_hole_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bhpq_pkg::ST_UP_RD || r_state == bhpq_pkg::ST_DN_RD)
        |-> (r_pos != '0 && r_pos <= r_count))
        else $error("sift hole outside the heap");

    // a refused command returns no entry
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bhpq_pkg::STATUS_OK)
        |-> (o_out_priority == '0 && o_out_tag == '0))
        else $error("refused command returned an entry");

endmodule
